### rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and helpers of the prefix and port match table
// Rule entry layout, search key layout, status codes and the byte masks
// that cut an address down to its leading bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [2:0] ST_MISS      = 3'd0;
  localparam logic [2:0] ST_HIT       = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Flag bits of a stored rule.
  localparam int FLAG_V6   = 0;
  localparam int FLAG_PORT = 1;

  // Key lengths in bytes that mean something special.
  localparam logic [4:0] KB_V4_FULL = 5'd4;
  localparam logic [4:0] KB_V6_32   = 5'd5;
  localparam logic [4:0] KB_V4_PORT = 5'd7;
  localparam logic [4:0] KB_V6_FULL = 5'd16;
  localparam logic [4:0] KB_V6_PORT = 5'd18;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [4:0]  key_bytes;
    logic [1:0]  flags;
  } entry_t;

  typedef struct packed {
    logic        lookup;
    logic        v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [4:0]  key_bytes;
    logic [1:0]  flags;
  } key_t;

  // Number of address bytes covered by a key length.
  function automatic logic [4:0] addr_bytes(input logic [4:0] kb);
    logic [4:0] n;
    n = kb;
    if (kb == KB_V6_32 || kb == KB_V4_PORT) n = 5'd4;
    if (kb == KB_V6_PORT) n = 5'd16;
    return n;
  endfunction

  // Mask that keeps the leading n bytes of an address of either family.
  function automatic logic [127:0] addr_mask(input logic v6, input logic [4:0] n);
    logic [127:0] m;
    m = '0;
    for (int j = 0; j < 16; j++) begin
      if (v6) begin
        if (5'(j) < n) m[127 - 8*j -: 8] = 8'hFF;
      end else if (j < 4) begin
        if (5'(j) < n) m[31 - 8*j -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/ip_prefix_port_match_table_top.sv
// ----------------------------------------------------------------------------
// ip_prefix_port_match_table_top: IPv4/IPv6 rule table with longest match
// Insert and lookup of byte-granular prefix, full address and port rules.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Every
// transaction returns exactly one result, shown for one cycle with done
// high; the receiver cannot stall it, so it must take the result in that
// cycle. The block walks the stored rules through one compare unit, one
// rule per cycle, reading them from a table with one write port, one read
// port and registered read data. An insert that carries an invalid prefix
// skips the walk and goes straight to the resolve step. A full table holds
// 64 rules, and busy is low again in the cycle that carries the result.
// Lookups return the matching rule of the same family with the greatest
// key length; the earliest stored rule wins a tie. Inserts report
// duplicates before a full table. Rules are never removed; the table
// needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_prefix_port_match_table_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire        req_type,
  input  wire        is_ipv6,
  input  wire [63:0] addr_high,
  input  wire [63:0] addr_low,
  input  wire [15:0] port_number,
  input  wire        with_port,
  input  wire [7:0]  prefix_bits,
  output logic       done,
  output logic [2:0] status,
  output logic [5:0] entry_index,
  output logic [4:0] key_bytes
);
  import lpm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE
  } state_t;

  state_t           state;
  key_t             key;
  logic             bad_prefix;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] issue_cnt;
  logic             pipe_valid;
  logic [IDX_W-1:0] pipe_idx;
  logic [4:0]       best_kb;
  logic [IDX_W-1:0] best_idx;
  logic             dup_found;
  logic [IDX_W-1:0] dup_idx;

  // Key formed from the request ports at accept time.
  key_t         key_next;
  logic         bad_next;
  logic [4:0]   pref_b;
  logic [127:0] ins_mask;

  logic         accept;
  logic         match;
  entry_t       rdata;
  entry_t       wdata;
  logic         we;
  logic         table_full;

  assign accept     = start && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign table_full = (fill_count >= CNT_W'(TABLE_ENTRIES));

  // Classify the request and build the search key. Insert keys are
  // masked here so that stored rules hold only their covered bytes.
  always_comb begin
    pref_b             = prefix_bits[7:3];
    bad_next           = 1'b0;
    key_next.lookup    = req_type;
    key_next.v6        = is_ipv6;
    key_next.addr_high = is_ipv6 ? addr_high : 64'd0;
    key_next.addr_low  = is_ipv6 ? addr_low : {32'd0, addr_low[31:0]};
    key_next.flags     = {with_port, is_ipv6};
    key_next.port      = with_port ? port_number : 16'd0;
    if (with_port) begin
      key_next.key_bytes = is_ipv6 ? KB_V6_PORT : KB_V4_PORT;
    end else if (prefix_bits == 8'd0) begin
      key_next.key_bytes = is_ipv6 ? KB_V6_FULL : KB_V4_FULL;
    end else begin
      if (!is_ipv6) begin
        bad_next = (pref_b == 5'd0) || (pref_b > 5'd3);
      end else begin
        bad_next = (pref_b < 5'd4) || (pref_b == 5'd5) || (pref_b == 5'd7) ||
                   (pref_b == 5'd9) || (pref_b > 5'd16);
      end
      key_next.key_bytes = (is_ipv6 && pref_b == 5'd4) ? KB_V6_32 : pref_b;
    end
    ins_mask = addr_mask(is_ipv6, addr_bytes(key_next.key_bytes));
    if (req_type) begin
      // Lookups carry the packet port and keep the full address.
      key_next.port      = port_number;
      key_next.flags     = {1'b0, is_ipv6};
      key_next.key_bytes = 5'd0;
      bad_next           = 1'b0;
    end else begin
      key_next.addr_high = key_next.addr_high & ins_mask[127:64];
      key_next.addr_low  = key_next.addr_low & ins_mask[63:0];
    end
  end

  // New rule written in the resolve cycle of a successful insert.
  always_comb begin
    wdata.addr_high = key.addr_high;
    wdata.addr_low  = key.addr_low;
    wdata.port      = key.port;
    wdata.key_bytes = key.key_bytes;
    wdata.flags     = key.flags;
    we = (state == S_RESOLVE) && !key.lookup && !bad_prefix && !dup_found &&
         !table_full;
  end

  lpm_table u_table (
    .clk   (clk),
    .we    (we),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (wdata),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  lpm_match u_match (
    .key   (key),
    .ent   (rdata),
    .match (match)
  );

  // Sequencer: issue one table read per cycle, compare the read rule in the next cycle,
  // then resolve the outcome and present the result for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      issue_cnt  <= '0;
      pipe_valid <= 1'b0;
      done       <= 1'b0;
      dup_found  <= 1'b0;
      best_kb    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= key_next;
            bad_prefix <= bad_next;
            issue_cnt  <= '0;
            pipe_valid <= 1'b0;
            dup_found  <= 1'b0;
            best_kb    <= '0;
            best_idx   <= '0;
            dup_idx    <= '0;
            state      <= bad_next ? S_RESOLVE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_cnt != fill_count) begin
            pipe_valid <= 1'b1;
            pipe_idx   <= issue_cnt[IDX_W-1:0];
            issue_cnt  <= issue_cnt + 1'b1;
          end else begin
            pipe_valid <= 1'b0;
            if (!pipe_valid) begin
              state <= S_RESOLVE;
            end
          end
          if (pipe_valid && match) begin
            if (key.lookup) begin
              if (rdata.key_bytes > best_kb) begin
                best_kb  <= rdata.key_bytes;
                best_idx <= pipe_idx;
              end
            end else if (!dup_found) begin
              dup_found <= 1'b1;
              dup_idx   <= pipe_idx;
            end
          end
        end
        S_RESOLVE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (key.lookup) begin
            status      <= (best_kb == 5'd0) ? ST_MISS : ST_HIT;
            entry_index <= 6'(best_idx);
            key_bytes   <= best_kb;
          end else if (bad_prefix) begin
            status      <= ST_INVALID;
            entry_index <= '0;
            key_bytes   <= '0;
          end else if (dup_found) begin
            status      <= ST_DUPLICATE;
            entry_index <= 6'(dup_idx);
            key_bytes   <= key.key_bytes;
          end else if (table_full) begin
            status      <= ST_FULL;
            entry_index <= '0;
            key_bytes   <= '0;
          end else begin
            status      <= ST_INSERTED;
            entry_index <= 6'(fill_count[IDX_W-1:0]);
            key_bytes   <= key.key_bytes;
            fill_count  <= fill_count + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result strobe only follows the resolve step.
  a_done_after_resolve: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RESOLVE))
    else $error("result strobe without a resolve step");

  // The rule count never exceeds the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_ENTRIES))
    else $error("rule count beyond table size");

  // A reported insert always added exactly one rule.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> (fill_count == $past(fill_count) + 1'b1))
    else $error("insert reported without a stored rule");

  // Compares are only in flight while scanning.
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    pipe_valid |-> (state == S_SCAN))
    else $error("compare pending outside the scan");

endmodule

`default_nettype wire

### rtl/lpm_table.sv
// ----------------------------------------------------------------------------
// lpm_table: rule storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_table (
  input  wire                   clk,
  input  wire                   we,
  input  wire [lpm_pkg::IDX_W-1:0] waddr,
  input  lpm_pkg::entry_t       wdata,
  input  wire [lpm_pkg::IDX_W-1:0] raddr,
  output lpm_pkg::entry_t       rdata
);
  import lpm_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lpm_match.sv
// ----------------------------------------------------------------------------
// lpm_match: rule compare unit
// Compares the search key with one stored rule, either as a lookup
// (masked by the rule's length) or as an exact duplicate check for insert.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_match (
  input  lpm_pkg::key_t   key,
  input  lpm_pkg::entry_t ent,
  output logic            match
);
  import lpm_pkg::*;

  logic [127:0] mask;
  logic [127:0] masked;
  logic         lk_hit;
  logic         dup_hit;

  always_comb begin
    mask    = addr_mask(key.v6, addr_bytes(ent.key_bytes));
    masked  = {key.addr_high, key.addr_low} & mask;
    lk_hit  = (ent.flags[FLAG_V6] == key.v6) &&
              (!ent.flags[FLAG_PORT] || ent.port == key.port) &&
              (masked == {ent.addr_high, ent.addr_low});
    dup_hit = (ent.key_bytes == key.key_bytes) && (ent.flags == key.flags) &&
              (ent.addr_high == key.addr_high) && (ent.addr_low == key.addr_low) &&
              (ent.port == key.port);
    match   = key.lookup ? lk_hit : dup_hit;
  end

endmodule

`default_nettype wire
